### rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg: shared constants for the line rasterizer
// Field widths, command codes, register reset value and queue sizing.
// ----------------------------------------------------------------------------
package lr_pkg;

  // Default coordinate width (columns and rows)
  localparam int COORD_BITS_DEF = 10;

  // Fixed field widths
  localparam int COLOR_BITS     = 32;
  localparam int INDEX_BITS     = 20;
  localparam int ROW_WIDTH_BITS = 11;

  // Row width after reset
  localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 11'd320;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Decoded-request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

endpackage

### rtl/lr_cmd_if.sv
// ----------------------------------------------------------------------------
// lr_cmd_if: command channel
// Valid/ready channel that carries one load or step request.
// ----------------------------------------------------------------------------
interface lr_cmd_if #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [COORD_BITS-1:0]         start_x;
  logic [COORD_BITS-1:0]         start_y;
  logic [COORD_BITS-1:0]         finish_x;
  logic [COORD_BITS-1:0]         finish_y;
  logic [lr_pkg::COLOR_BITS-1:0] line_color;

  modport source (
    output valid, command, start_x, start_y, finish_x, finish_y, line_color,
    input  ready
  );

  modport sink (
    input  valid, command, start_x, start_y, finish_x, finish_y, line_color,
    output ready
  );
endinterface

### rtl/lr_pix_if.sv
// ----------------------------------------------------------------------------
// lr_pix_if: pixel channel
// Valid/ready channel that carries one rasterized pixel.
// ----------------------------------------------------------------------------
interface lr_pix_if #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [COORD_BITS-1:0]         pixel_x;
  logic [COORD_BITS-1:0]         pixel_y;
  logic [lr_pkg::INDEX_BITS-1:0] pixel_index;
  logic [lr_pkg::COLOR_BITS-1:0] pixel_color;
  logic                          last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_index, pixel_color, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_index, pixel_color, last,
    output ready
  );
endinterface

### rtl/lr_front.sv
// ----------------------------------------------------------------------------
// lr_front: request decode and queue
// Accepts requests, precomputes the line setup for loads and holds the
// decoded requests in a short queue for the stepping engine.
// ----------------------------------------------------------------------------
module lr_front #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  lr_cmd_if.sink                        cmd,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic                          q_is_load,
  output logic [COORD_BITS-1:0]         q_start_x,
  output logic [COORD_BITS-1:0]         q_start_y,
  output logic [COORD_BITS-1:0]         q_goal_x,
  output logic [COORD_BITS-1:0]         q_goal_y,
  output logic [lr_pkg::COLOR_BITS-1:0] q_color,
  output logic [COORD_BITS:0]           q_twice_dx,
  output logic [COORD_BITS:0]           q_twice_dy,
  output logic                          q_x_negative,
  output logic                          q_y_negative,
  output logic                          q_x_major,
  output logic signed [COORD_BITS+2:0]  q_error,
  output logic                          q_last
);

  localparam int EW = COORD_BITS + 3;

  typedef struct packed {
    logic                          is_load;
    logic [COORD_BITS-1:0]         start_x;
    logic [COORD_BITS-1:0]         start_y;
    logic [COORD_BITS-1:0]         goal_x;
    logic [COORD_BITS-1:0]         goal_y;
    logic [lr_pkg::COLOR_BITS-1:0] color;
    logic [COORD_BITS:0]           twice_dx;
    logic [COORD_BITS:0]           twice_dy;
    logic                          x_negative;
    logic                          y_negative;
    logic                          x_major;
    logic signed [EW-1:0]          error;
    logic                          last;
  } entry_t;

  entry_t                        dec;
  entry_t                        mem [lr_pkg::QUEUE_DEPTH];
  logic [lr_pkg::QPTR_BITS-1:0]  wr_ptr;
  logic [lr_pkg::QPTR_BITS-1:0]  rd_ptr;
  logic [lr_pkg::QCNT_BITS-1:0]  count;
  logic                          push;
  logic                          pop;
  logic signed [COORD_BITS:0]    dx;
  logic signed [COORD_BITS:0]    dy;
  logic [COORD_BITS:0]           dx_abs;
  logic [COORD_BITS:0]           dy_abs;

  // Decode the request: deltas, directions, major axis, initial error
  always_comb begin
    dx     = $signed({1'b0, cmd.finish_x}) - $signed({1'b0, cmd.start_x});
    dy     = $signed({1'b0, cmd.finish_y}) - $signed({1'b0, cmd.start_y});
    dx_abs = dx[COORD_BITS] ? (-dx) : dx;
    dy_abs = dy[COORD_BITS] ? (-dy) : dy;

    dec.is_load    = (cmd.command == lr_pkg::CMD_LOAD);
    dec.start_x    = cmd.start_x;
    dec.start_y    = cmd.start_y;
    dec.goal_x     = cmd.finish_x;
    dec.goal_y     = cmd.finish_y;
    dec.color      = cmd.line_color;
    dec.x_negative = dx[COORD_BITS];
    dec.y_negative = dy[COORD_BITS];
    dec.twice_dx   = {dx_abs[COORD_BITS-1:0], 1'b0};
    dec.twice_dy   = {dy_abs[COORD_BITS-1:0], 1'b0};
    dec.x_major    = dec.twice_dx > dec.twice_dy;
    if (dec.x_major) begin
      dec.error = $signed({2'b00, dec.twice_dy}) - $signed({2'b00, dx_abs});
      dec.last  = (cmd.start_x == cmd.finish_x);
    end else begin
      dec.error = $signed({2'b00, dec.twice_dx}) - $signed({2'b00, dy_abs});
      dec.last  = (cmd.start_y == cmd.finish_y);
    end
  end

  assign cmd.ready = (count != lr_pkg::QCNT_BITS'(lr_pkg::QUEUE_DEPTH));
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != '0);
  assign pop       = q_valid && q_ready;

  // Store decoded requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= dec;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lr_pkg::QPTR_BITS'(lr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lr_pkg::QPTR_BITS'(lr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Present the queue head
  assign q_is_load    = mem[rd_ptr].is_load;
  assign q_start_x    = mem[rd_ptr].start_x;
  assign q_start_y    = mem[rd_ptr].start_y;
  assign q_goal_x     = mem[rd_ptr].goal_x;
  assign q_goal_y     = mem[rd_ptr].goal_y;
  assign q_color      = mem[rd_ptr].color;
  assign q_twice_dx   = mem[rd_ptr].twice_dx;
  assign q_twice_dy   = mem[rd_ptr].twice_dy;
  assign q_x_negative = mem[rd_ptr].x_negative;
  assign q_y_negative = mem[rd_ptr].y_negative;
  assign q_x_major    = mem[rd_ptr].x_major;
  assign q_error      = mem[rd_ptr].error;
  assign q_last       = mem[rd_ptr].last;

endmodule

### rtl/lr_back.sv
// ----------------------------------------------------------------------------
// lr_back: Bresenham stepping engine
// Holds the line state, carries out load and step requests and registers
// one pixel (coordinates, color, last flag) per request that produces one.
// ----------------------------------------------------------------------------
module lr_back #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic                          q_is_load,
  input  logic [COORD_BITS-1:0]         q_start_x,
  input  logic [COORD_BITS-1:0]         q_start_y,
  input  logic [COORD_BITS-1:0]         q_goal_x,
  input  logic [COORD_BITS-1:0]         q_goal_y,
  input  logic [lr_pkg::COLOR_BITS-1:0] q_color,
  input  logic [COORD_BITS:0]           q_twice_dx,
  input  logic [COORD_BITS:0]           q_twice_dy,
  input  logic                          q_x_negative,
  input  logic                          q_y_negative,
  input  logic                          q_x_major,
  input  logic signed [COORD_BITS+2:0]  q_error,
  input  logic                          q_last,
  output logic                          p_valid,
  input  logic                          p_ready,
  output logic [COORD_BITS-1:0]         p_x,
  output logic [COORD_BITS-1:0]         p_y,
  output logic [lr_pkg::COLOR_BITS-1:0] p_color,
  output logic                          p_last
);

  localparam int EW = COORD_BITS + 3;

  // Line state
  logic [COORD_BITS-1:0]         cur_x;
  logic [COORD_BITS-1:0]         cur_y;
  logic [COORD_BITS-1:0]         goal_x;
  logic [COORD_BITS-1:0]         goal_y;
  logic [COORD_BITS:0]           twice_dx;
  logic [COORD_BITS:0]           twice_dy;
  logic                          x_negative;
  logic                          y_negative;
  logic                          x_major;
  logic signed [EW-1:0]          error_term;
  logic                          busy;
  logic [lr_pkg::COLOR_BITS-1:0] held_color;

  logic                          can_emit;
  logic                          emits;
  logic                          fire;
  logic                          minor_move;
  logic [COORD_BITS-1:0]         cur_x_next;
  logic [COORD_BITS-1:0]         cur_y_next;
  logic signed [EW-1:0]          error_next;
  logic                          step_last;

  // Hold the request when the pixel register is full and cannot drain
  assign can_emit = !p_valid || p_ready;
  assign emits    = q_is_load || busy;
  assign q_ready  = emits ? can_emit : 1'b1;
  assign fire     = q_valid && q_ready;

  // One Bresenham step along the major axis
  always_comb begin
    minor_move = !error_term[EW-1];
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    error_next = error_term;
    if (x_major) begin
      if (minor_move) begin
        cur_y_next = y_negative ? cur_y - 1'b1 : cur_y + 1'b1;
        error_next = error_term - $signed({2'b00, twice_dx});
      end
      cur_x_next = x_negative ? cur_x - 1'b1 : cur_x + 1'b1;
      error_next = error_next + $signed({2'b00, twice_dy});
      step_last  = (cur_x_next == goal_x);
    end else begin
      if (minor_move) begin
        cur_x_next = x_negative ? cur_x - 1'b1 : cur_x + 1'b1;
        error_next = error_term - $signed({2'b00, twice_dy});
      end
      cur_y_next = y_negative ? cur_y - 1'b1 : cur_y + 1'b1;
      error_next = error_next + $signed({2'b00, twice_dx});
      step_last  = (cur_y_next == goal_y);
    end
  end

  // Control state: busy flag and pixel register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      if (fire && q_is_load) begin
        busy <= !q_last;
      end else if (fire && busy) begin
        busy <= !step_last;
      end
      if (fire && emits) begin
        p_valid <= 1'b1;
      end else if (p_ready) begin
        p_valid <= 1'b0;
      end
    end
  end

  // Line state and pixel payload
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      goal_x     <= '0;
      goal_y     <= '0;
      twice_dx   <= '0;
      twice_dy   <= '0;
      x_negative <= 1'b0;
      y_negative <= 1'b0;
      x_major    <= 1'b0;
      error_term <= '0;
      held_color <= '0;
    end else if (fire && q_is_load) begin
      cur_x      <= q_start_x;
      cur_y      <= q_start_y;
      goal_x     <= q_goal_x;
      goal_y     <= q_goal_y;
      twice_dx   <= q_twice_dx;
      twice_dy   <= q_twice_dy;
      x_negative <= q_x_negative;
      y_negative <= q_y_negative;
      x_major    <= q_x_major;
      error_term <= q_error;
      held_color <= q_color;
    end else if (fire && busy) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      error_term <= error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && q_is_load) begin
      p_x     <= q_start_x;
      p_y     <= q_start_y;
      p_color <= q_color;
      p_last  <= q_last;
    end else if (fire && busy) begin
      p_x     <= cur_x_next;
      p_y     <= cur_y_next;
      p_color <= held_color;
      p_last  <= step_last;
    end
  end

endmodule

### rtl/lr_index.sv
// ----------------------------------------------------------------------------
// lr_index: framebuffer index stage
// Holds the row width register, forms y * row_width + x for each pixel and
// registers the finished pixel toward the output channel.
// ----------------------------------------------------------------------------
module lr_index #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lr_pkg::ROW_WIDTH_BITS-1:0] cfg_wdata,
  input  logic                              p_valid,
  output logic                              p_ready,
  input  logic [COORD_BITS-1:0]             p_x,
  input  logic [COORD_BITS-1:0]             p_y,
  input  logic [lr_pkg::COLOR_BITS-1:0]     p_color,
  input  logic                              p_last,
  lr_pix_if.source                          pix
);

  localparam int SUM_BITS = COORD_BITS + lr_pkg::ROW_WIDTH_BITS + 1;
  localparam int MW = (SUM_BITS > lr_pkg::INDEX_BITS) ? SUM_BITS : lr_pkg::INDEX_BITS;

  logic [lr_pkg::ROW_WIDTH_BITS-1:0] row_width;
  logic [MW-1:0]                     sum;
  logic                              out_valid;
  logic [COORD_BITS-1:0]             out_x;
  logic [COORD_BITS-1:0]             out_y;
  logic [lr_pkg::INDEX_BITS-1:0]     out_index;
  logic [lr_pkg::COLOR_BITS-1:0]     out_color;
  logic                              out_last;

  // Row width register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= lr_pkg::ROW_WIDTH_RESET;
    end else if (cfg_we) begin
      row_width <= cfg_wdata;
    end
  end

  // Linear index, wrapped to the index width
  assign sum = MW'(p_y) * MW'(row_width) + MW'(p_x);

  assign p_ready = !out_valid || pix.ready;

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_ready) begin
      out_valid <= p_valid;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (p_ready && p_valid) begin
      out_x     <= p_x;
      out_y     <= p_y;
      out_index <= sum[lr_pkg::INDEX_BITS-1:0];
      out_color <= p_color;
      out_last  <= p_last;
    end
  end

  assign pix.valid       = out_valid;
  assign pix.pixel_x     = out_x;
  assign pix.pixel_y     = out_y;
  assign pix.pixel_index = out_index;
  assign pix.pixel_color = out_color;
  assign pix.last        = out_last;

endmodule

### rtl/line_rasterizer.sv
// Path: a request accepted into the queue passes through the stepping engine
// register and the index register before its pixel shows on the pixel channel.
// Throughput: one request per cycle, one pixel per cycle while pix.ready holds,
// set by the single Bresenham step and the one index multiplier in the output stage.
// Reset (rst, synchronous): queue empty, line idle, row width 320.
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line rasterizer
// Load requests set up a line and emit its start pixel, step requests emit
// the following pixels with their framebuffer index while a line is in progress.
// ----------------------------------------------------------------------------
module line_rasterizer #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lr_pkg::ROW_WIDTH_BITS-1:0] cfg_wdata,
  lr_cmd_if.sink                            cmd,
  lr_pix_if.source                          pix
);

  logic                          q_valid;
  logic                          q_ready;
  logic                          q_is_load;
  logic [COORD_BITS-1:0]         q_start_x;
  logic [COORD_BITS-1:0]         q_start_y;
  logic [COORD_BITS-1:0]         q_goal_x;
  logic [COORD_BITS-1:0]         q_goal_y;
  logic [lr_pkg::COLOR_BITS-1:0] q_color;
  logic [COORD_BITS:0]           q_twice_dx;
  logic [COORD_BITS:0]           q_twice_dy;
  logic                          q_x_negative;
  logic                          q_y_negative;
  logic                          q_x_major;
  logic signed [COORD_BITS+2:0]  q_error;
  logic                          q_last;

  logic                          p_valid;
  logic                          p_ready;
  logic [COORD_BITS-1:0]         p_x;
  logic [COORD_BITS-1:0]         p_y;
  logic [lr_pkg::COLOR_BITS-1:0] p_color;
  logic                          p_last;

  // Decode and queue requests
  lr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_is_load    (q_is_load),
    .q_start_x    (q_start_x),
    .q_start_y    (q_start_y),
    .q_goal_x     (q_goal_x),
    .q_goal_y     (q_goal_y),
    .q_color      (q_color),
    .q_twice_dx   (q_twice_dx),
    .q_twice_dy   (q_twice_dy),
    .q_x_negative (q_x_negative),
    .q_y_negative (q_y_negative),
    .q_x_major    (q_x_major),
    .q_error      (q_error),
    .q_last       (q_last)
  );

  // Step along the line
  lr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_is_load    (q_is_load),
    .q_start_x    (q_start_x),
    .q_start_y    (q_start_y),
    .q_goal_x     (q_goal_x),
    .q_goal_y     (q_goal_y),
    .q_color      (q_color),
    .q_twice_dx   (q_twice_dx),
    .q_twice_dy   (q_twice_dy),
    .q_x_negative (q_x_negative),
    .q_y_negative (q_y_negative),
    .q_x_major    (q_x_major),
    .q_error      (q_error),
    .q_last       (q_last),
    .p_valid      (p_valid),
    .p_ready      (p_ready),
    .p_x          (p_x),
    .p_y          (p_y),
    .p_color      (p_color),
    .p_last       (p_last)
  );

  // Form the framebuffer index and drive the pixel channel
  lr_index #(.COORD_BITS(COORD_BITS)) u_index (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .p_valid   (p_valid),
    .p_ready   (p_ready),
    .p_x       (p_x),
    .p_y       (p_y),
    .p_color   (p_color),
    .p_last    (p_last),
    .pix       (pix)
  );

endmodule
